// ===== sv/mbrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrf_pkg
// Shared types, constants and functions for the Modbus RTU request framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrf_pkg;

   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int OFS_W    = 4;
   localparam int TEMP_W   = 16;
   localparam int CRC_W    = 16;
   localparam int IDX_W    = 4;
   localparam int REQ_DATA_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_WR_SETPOINT = 2'd0,
      CMD_WR_MODE     = 2'd1,
      CMD_RD_STATUS   = 2'd2,
      CMD_RD_CORRECT  = 2'd3
   } cmd_type;

   localparam logic [BYTE_W-1:0] FN_READ_HOLD    = 8'h03;
   localparam logic [BYTE_W-1:0] FN_WRITE_SINGLE = 8'h06;
   localparam logic [BYTE_W-1:0] FN_WRITE_MULTI  = 8'h10;

   localparam logic [BYTE_W-1:0] REG_MODE        = 8'h02;
   localparam logic [BYTE_W-1:0] REG_CORRECTION  = 8'h14;
   localparam logic [BYTE_W-1:0] REG_SETPOINT    = 8'h05;
   localparam logic [BYTE_W-1:0] STATUS_COUNT    = 8'h06;
   localparam logic [BYTE_W-1:0] CORRECT_COUNT   = 8'h01;
   localparam logic [BYTE_W-1:0] MULTI_REG_COUNT = 8'h03;
   localparam logic [BYTE_W-1:0] MULTI_BYTE_CNT  = 8'h06;

   localparam logic [IDX_W-1:0]  LONG_BODY_LEN   = 4'd13;
   localparam logic [IDX_W-1:0]  SHORT_BODY_LEN  = 4'd6;

   localparam logic [CRC_W-1:0]  CRC_INIT        = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY        = 16'hA001;

   localparam logic [OFS_W:0]    TEMP_BASE       = 5'd16;
   localparam logic [6:0]        TEMP_SCALE      = 7'd100;

   typedef struct packed {
      cmd_type               cmd;
      logic [BYTE_W-1:0]     addr;
      logic [BYTE_W-1:0]     mode_byte;
      logic [TEMP_W-1:0]     temp;
      logic [BYTE_W-1:0]     fan;
   } desc_type;

   function automatic logic [BYTE_W-1:0] map_mode(input logic [BYTE_W-1:0] code);
      logic [BYTE_W-1:0] res;
      res = 8'h00;
      if (code[0]) begin
         unique case (code)
            8'd1:    res = 8'h05;
            8'd17:   res = 8'h02;
            8'd33:   res = 8'h04;
            8'd49:   res = 8'h01;
            8'd65:   res = 8'h03;
            default: res = 8'h00;
         endcase
      end
      return res;
   endfunction

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] r;
      r = crc ^ {8'h00, data};
      for (int b = 0; b < BYTE_W; b++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] body_len(input cmd_type cmd);
      return (cmd == CMD_WR_SETPOINT) ? LONG_BODY_LEN : SHORT_BODY_LEN;
   endfunction

   function automatic logic [BYTE_W-1:0] body_byte(input desc_type d,
                                                   input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] res;
      res = 8'h00;
      if (d.cmd == CMD_WR_SETPOINT) begin
         unique case (idx)
            4'd0:    res = d.addr;
            4'd1:    res = FN_WRITE_MULTI;
            4'd3:    res = REG_SETPOINT;
            4'd5:    res = MULTI_REG_COUNT;
            4'd6:    res = MULTI_BYTE_CNT;
            4'd7:    res = d.temp[15:8];
            4'd8:    res = d.temp[7:0];
            4'd12:   res = d.fan;
            default: res = 8'h00;
         endcase
      end else begin
         unique case (idx)
            4'd0:    res = d.addr;
            4'd1:    res = (d.cmd == CMD_WR_MODE) ? FN_WRITE_SINGLE : FN_READ_HOLD;
            4'd3:    res = (d.cmd == CMD_RD_CORRECT) ? REG_CORRECTION : REG_MODE;
            4'd5:    res = d.mode_byte;
            default: res = 8'h00;
         endcase
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/modbus_ac_request_framer.sv =====
// ----------------------------------------------------------------------------
// modbus_ac_request_framer
// Builds Modbus RTU request frames with CRC-16/Modbus for an AC gateway.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_*): one request per handshake; req_tuser holds the
//   command, req_tdata the address, mode code, setpoint offset and fan speed.
//   Result channel (rsp_*): one frame byte per handshake in transmit order,
//   rsp_tlast set on the CRC high byte that closes the frame.
//   On an idle block an accepted request is written into the queue, then
//   loaded into the serialiser, which registers its first byte for output.
//   Throughput: one byte per cycle from the serialiser when the receiver is
//   ready; a setpoint frame is 15 bytes, the others 8, with no gap between.
//   A queue of QUEUE_DEPTH decoded requests lets new requests be accepted
//   while a frame is still being sent; req_tready drops only when it is full.
//   Reset empties the queue and the output register; nothing else is kept.
//   When the receiver stalls the current byte is held in the output register
//   and the serialiser waits; the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_ac_request_framer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [7:0] slave_address, [15:8] mode_request, [19:16] setpoint_offset,
   // [27:20] fan_speed, [31:28] zero
   input  wire logic [mbrf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] command
   input  wire logic [mbrf_pkg::CMD_W-1:0]          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] frame_byte
   output logic [mbrf_pkg::BYTE_W-1:0]              rsp_tdata,
   output logic                                     rsp_tlast
);
   import mbrf_pkg::*;

   desc_type front_desc;
   desc_type q_head;
   logic     q_not_full, q_not_empty, q_pop;

   mbrf_front u_front (
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser),
      .req_data  (req_tdata),
      .desc      (front_desc)
   );

   mbrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (front_desc),
      .not_full  (q_not_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .head      (q_head)
   );

   mbrf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   assign req_tready = q_not_full;

endmodule

`default_nettype wire

// ===== sv/mbrf_front.sv =====
// ----------------------------------------------------------------------------
// mbrf_front
// Request intake: decodes the command, maps the mode and scales the setpoint.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrf_front (
   input  wire logic                             req_valid,
   input  wire logic [mbrf_pkg::CMD_W-1:0]       req_cmd,
   input  wire logic [mbrf_pkg::REQ_DATA_W-1:0]  req_data,
   output mbrf_pkg::desc_type                    desc
);
   import mbrf_pkg::*;

   logic [OFS_W:0]  ofs_ext;
   logic [TEMP_W-1:0] temp;
   cmd_type         cmd;
   logic [BYTE_W-1:0] mode_val;

   assign cmd     = cmd_type'(req_cmd);
   assign ofs_ext = {1'b0, req_data[19:16]} + TEMP_BASE;
   assign temp    = TEMP_W'(ofs_ext) * TEMP_W'(TEMP_SCALE);

   // read frames carry a fixed register count in byte five
   always_comb begin
      unique case (cmd)
         CMD_WR_MODE:    mode_val = map_mode(req_data[15:8]);
         CMD_RD_STATUS:  mode_val = STATUS_COUNT;
         CMD_RD_CORRECT: mode_val = CORRECT_COUNT;
         default:        mode_val = 8'h00;
      endcase
   end

   always_comb begin
      desc           = '0;
      desc.cmd       = cmd;
      desc.addr      = req_data[7:0];
      desc.mode_byte = req_valid ? mode_val : 8'h00;
      desc.temp      = temp;
      desc.fan       = req_data[27:20];
   end

endmodule

`default_nettype wire

// ===== sv/mbrf_queue.sv =====
// ----------------------------------------------------------------------------
// mbrf_queue
// Small register queue of decoded requests between intake and serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrf_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire mbrf_pkg::desc_type push_data,
   output logic               not_full,
   output logic               not_empty,
   input  wire logic          pop,
   output mbrf_pkg::desc_type head
);
   import mbrf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              do_push, do_pop;

   assign not_full  = (count_ff != CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mbrf_back.sv =====
// ----------------------------------------------------------------------------
// mbrf_back
// Frame serialiser: emits body bytes one per cycle unless the output stalls,
// folds them into CRC-16/Modbus, appends the CRC low byte then high byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrf_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire mbrf_pkg::desc_type          q_head,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [mbrf_pkg::BYTE_W-1:0]      rsp_tdata,
   output logic                             rsp_tlast
);
   import mbrf_pkg::*;

   desc_type          desc_ff,   desc_in;
   logic              active_ff, active_in;
   logic [IDX_W-1:0]  idx_ff,    idx_in;
   logic [CRC_W-1:0]  crc_ff,    crc_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff,  out_data_in;
   logic              out_last_ff,  out_last_in;

   logic              adv, emit, is_last;
   logic [IDX_W-1:0]  blen;
   logic [BYTE_W-1:0] cur_byte;

   assign adv      = !out_valid_ff || rsp_tready;
   assign emit     = active_ff && adv;
   assign blen     = body_len(desc_ff.cmd);
   assign is_last  = (idx_ff == blen + 1'b1);
   assign q_pop    = q_valid && (!active_ff || (emit && is_last));

   always_comb begin
      if (idx_ff < blen) begin
         cur_byte = body_byte(desc_ff, idx_ff);
      end else if (idx_ff == blen) begin
         cur_byte = crc_ff[7:0];
      end else begin
         cur_byte = crc_ff[15:8];
      end
   end

   always_comb begin
      desc_in      = desc_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_data_in  = cur_byte;
         out_last_in  = is_last;
         idx_in       = idx_ff + 1'b1;
         if (idx_ff < blen) begin
            crc_in = crc_byte(crc_ff, cur_byte);
         end
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      if (q_pop) begin
         desc_in   = q_head;
         active_in = 1'b1;
         idx_in    = '0;
         crc_in    = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      desc_ff     <= desc_in;
      idx_ff      <= idx_in;
      crc_ff      <= crc_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= blen + 1'b1))
      else $error("byte index past end of frame");

   a_pop_init: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (active_ff && idx_ff == '0 && crc_ff == CRC_INIT))
      else $error("new frame not initialised");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (emit && is_last && !q_pop) |=> !active_ff)
      else $error("serialiser still busy after last byte");

   a_pop_only_free: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !(emit && is_last)) |-> !q_pop)
      else $error("queue popped mid-frame");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the Modbus RTU request framer. Requests go in through a
// queue-fed driver, and each one is predicted as its full frame (body, CRC-16
// low then high byte, last flag on the closing byte). A monitor compares every
// frame byte as taken. Outside a steady window both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   import mbrf_pkg::cmd_type;
   import mbrf_pkg::CMD_WR_SETPOINT;
   import mbrf_pkg::CMD_WR_MODE;
   import mbrf_pkg::CMD_RD_STATUS;
   import mbrf_pkg::CMD_RD_CORRECT;

   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          DRAIN_CYCLES  = 20;
   localparam int          RANDOM_COUNT  = 360;
   localparam int          STEADY_FROM   = 1500;
   localparam int          STEADY_TO     = 2700;
   localparam logic [15:0] CRC_SEED      = 16'hFFFF;
   localparam logic [15:0] CRC_REFL_POLY = 16'hA001;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  addr;
      logic [7:0]  mode;
      logic [3:0]  ofs;
      logic [7:0]  fan;
   } ac_request_type;

   typedef struct packed {
      logic [7:0]  octet;
      logic        closing;
   } frame_octet_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   ac_request_type  pending_requests [$];
   frame_octet_type expected_octets [$];
   frame_octet_type want_octet;
   logic            req_fire = 1'b0;
   int              cycle_count = 0;
   int              error_count = 0;
   logic            steady;

   modbus_ac_request_framer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign steady = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);

   function automatic logic [7:0] ac_mode_byte(input logic [7:0] code);
      case (code)
         8'd1:    return 8'h05;
         8'd17:   return 8'h02;
         8'd33:   return 8'h04;
         8'd49:   return 8'h01;
         8'd65:   return 8'h03;
         default: return 8'h00;
      endcase
   endfunction

   // builds the frame for one request and appends its bytes to the expected list
   task automatic queue_frame(input cmd_type cmd, input logic [7:0] addr,
                              input logic [7:0] mode, input logic [3:0] ofs,
                              input logic [7:0] fan);
      logic [7:0]  body [0:12];
      logic [15:0] temp_c;
      logic [15:0] crc;
      int          len;
      frame_octet_type fo;
      temp_c = (16'(ofs) + 16'd16) * 16'd100;
      body[0] = addr;
      if (cmd == CMD_WR_SETPOINT) begin
         body[1] = mbrf_pkg::FN_WRITE_MULTI;
         body[2] = 8'h00;
         body[3] = mbrf_pkg::REG_SETPOINT;
         body[4] = 8'h00;
         body[5] = 8'h03;
         body[6] = 8'h06;
         body[7] = temp_c[15:8];
         body[8] = temp_c[7:0];
         body[9] = 8'h00;
         body[10] = 8'h00;
         body[11] = 8'h00;
         body[12] = fan;
         len = 13;
      end else begin
         body[2] = 8'h00;
         body[4] = 8'h00;
         case (cmd)
            CMD_WR_MODE: begin
               body[1] = mbrf_pkg::FN_WRITE_SINGLE;
               body[3] = mbrf_pkg::REG_MODE;
               body[5] = ac_mode_byte(mode);
            end
            CMD_RD_STATUS: begin
               body[1] = mbrf_pkg::FN_READ_HOLD;
               body[3] = mbrf_pkg::REG_MODE;
               body[5] = 8'h06;
            end
            default: begin
               body[1] = mbrf_pkg::FN_READ_HOLD;
               body[3] = mbrf_pkg::REG_CORRECTION;
               body[5] = 8'h01;
            end
         endcase
         len = 6;
      end
      crc = CRC_SEED;
      for (int i = 0; i < len; i++) begin
         crc = crc ^ {8'h00, body[i]};
         repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_REFL_POLY) : (crc >> 1);
      end
      for (int i = 0; i < len; i++) begin
         fo.octet = body[i];
         fo.closing = 1'b0;
         expected_octets.push_back(fo);
      end
      fo.octet = crc[7:0];
      fo.closing = 1'b0;
      expected_octets.push_back(fo);
      fo.octet = crc[15:8];
      fo.closing = 1'b1;
      expected_octets.push_back(fo);
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic add_request(input cmd_type cmd, input logic [7:0] addr,
                              input logic [7:0] mode, input logic [3:0] ofs,
                              input logic [7:0] fan);
      ac_request_type rq;
      rq.cmd = cmd;
      rq.addr = addr;
      rq.mode = mode;
      rq.ofs = ofs;
      rq.fan = fan;
      pending_requests.push_back(rq);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
   end

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_requests[0].cmd;
               req_tdata  <= {4'h0, pending_requests[0].fan, pending_requests[0].ofs,
                              pending_requests[0].mode, pending_requests[0].addr};
               pending_requests.delete(0);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 15);
      end
   end

   // prediction on request accept, check on byte accept
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            queue_frame(cmd_type'(req_tuser), req_tdata[7:0], req_tdata[15:8],
                        req_tdata[19:16], req_tdata[27:20]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_octets.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %b", rsp_tdata, rsp_tlast));
            end else begin
               want_octet = expected_octets.pop_front();
               if (rsp_tdata !== want_octet.octet) begin
                  report_mismatch($sformatf("frame byte %02h, expected %02h",
                                            rsp_tdata, want_octet.octet));
               end
               if (rsp_tlast !== want_octet.closing) begin
                  report_mismatch($sformatf("last flag %b, expected %b on byte %02h",
                                            rsp_tlast, want_octet.closing, want_octet.octet));
               end
            end
         end
      end
   end

   initial begin
      logic [7:0] mode_pool [0:5];
      logic [7:0] mode_pick;
      mode_pool = '{8'd0, 8'd1, 8'd17, 8'd33, 8'd49, 8'd65};

      // directed: every command, field extremes, each mode code, odd unmapped codes
      add_request(CMD_WR_SETPOINT, 8'h00, 8'h00, 4'd0,  8'h00);
      add_request(CMD_WR_SETPOINT, 8'hFF, 8'hFF, 4'd14, 8'hFF);
      add_request(CMD_WR_SETPOINT, 8'h01, 8'h55, 4'd15, 8'h80);
      add_request(CMD_WR_SETPOINT, 8'hA5, 8'h00, 4'd7,  8'h01);
      add_request(CMD_WR_MODE,     8'h01, 8'd0,  4'd0,  8'h00);
      add_request(CMD_WR_MODE,     8'h02, 8'd1,  4'd15, 8'hFF);
      add_request(CMD_WR_MODE,     8'h03, 8'd17, 4'd3,  8'h12);
      add_request(CMD_WR_MODE,     8'h04, 8'd33, 4'd9,  8'h34);
      add_request(CMD_WR_MODE,     8'h05, 8'd49, 4'd1,  8'h56);
      add_request(CMD_WR_MODE,     8'h06, 8'd65, 4'd2,  8'h78);
      add_request(CMD_WR_MODE,     8'hFF, 8'd3,  4'd0,  8'h00);
      add_request(CMD_WR_MODE,     8'h00, 8'd255, 4'd0, 8'h00);
      add_request(CMD_WR_MODE,     8'h7F, 8'd254, 4'd0, 8'h00);
      add_request(CMD_WR_MODE,     8'h80, 8'd67, 4'd0,  8'h00);
      add_request(CMD_RD_STATUS,   8'h00, 8'hFF, 4'd15, 8'hFF);
      add_request(CMD_RD_STATUS,   8'hFF, 8'h00, 4'd0,  8'h00);
      add_request(CMD_RD_STATUS,   8'h11, 8'd17, 4'd5,  8'hAA);
      add_request(CMD_RD_CORRECT,  8'h00, 8'hFF, 4'd15, 8'hFF);
      add_request(CMD_RD_CORRECT,  8'hFF, 8'h00, 4'd0,  8'h00);
      add_request(CMD_RD_CORRECT,  8'h2C, 8'd65, 4'd11, 8'h55);

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if ($urandom_range(1) == 0) begin
            mode_pick = mode_pool[$urandom_range(5)];
         end else begin
            mode_pick = 8'($urandom);
         end
         add_request(cmd_type'($urandom_range(3)), 8'($urandom), mode_pick,
                     4'($urandom_range(15)), 8'($urandom));
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_requests.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_octets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
